// ===== design/dnd_pkg.sv =====
// Shared types and constants for the DNS name decoder.
// Used by dnd_ctrl, dnd_datapath and dns_name_decoder_core; no dependencies.
`default_nettype none

package dnd_pkg;

    // Defaults for the top-level parameters
    localparam int PACKET_BYTES_DEF   = 512;
    localparam int MAX_NAME_CHARS_DEF = 127;

    // Read pointer holds a 14-bit pointer target or a position up to 16384
    localparam int RP_W = 15;
    localparam int HOPS_W = 6;
    localparam logic [HOPS_W-1:0] HOPS_RESET = 6'd16;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    // Configuration register select (paddr[2])
    localparam logic REG_MAX_HOPS = 1'b0;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_LONG = 2'd1,
        ERR_HOPS     = 2'd2,
        ERR_RANGE    = 2'd3
    } err_code_t;

    // Controller to datapath
    typedef struct packed {
        logic      start;       // take decode start offset, clear walk state
        logic      store_wr;    // write packet byte
        logic      rd_next;     // packet read at rp+1 instead of rp
        logic      set_end1;    // end offset past terminator
        logic      set_end2;    // end offset past first pointer
        logic      hop;         // count pointer, keep its high bits
        logic      jump;        // rp <= pointer target
        logic      put_dot;
        logic      lbl_open;    // rem <= length byte, rp++
        logic      put_char;    // append packet byte, rp++, rem--
        logic      flush;       // write partial group row
        logic      emit_ld;     // load output register from name row
        logic      emit_next;   // next name row
        logic      err_ld;      // load error result
        err_code_t err_code;
    } dnd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rp_oob;
        logic next_oob;
        logic byte_zero;
        logic byte_ptr;
        logic hops_out;
        logic name_full;
        logic seen;
        logic rem_zero;
        logic out_last;
    } dnd_status_t;

endpackage

`default_nettype wire

// ===== design/dnd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/dnd_ctrl.sv =====
// Decoder controller: sequences store beats, the name walk and result emission.
// Depends on dnd_pkg; drives dnd_datapath through dnd_cmd_t.
`default_nettype none

module dnd_ctrl
    import dnd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_cmd,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire dnd_status_t status,
    output dnd_cmd_t         ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_PTR,
        S_LBL,
        S_CHR,
        S_FLUSH,
        S_EMIT_RD,
        S_EMIT_LD,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd)
                    begin
                        ctl.start  = 1'b1;
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        ctl.store_wr = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                if (status.rp_oob)
                begin
                    ctl.err_ld   = 1'b1;
                    ctl.err_code = ERR_RANGE;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (status.byte_zero)
                begin
                    ctl.set_end1 = 1'b1;
                    state_next   = S_FLUSH;
                end
                else if (status.byte_ptr)
                begin
                    ctl.set_end2 = 1'b1;
                    priority if (status.next_oob)
                    begin
                        ctl.err_ld   = 1'b1;
                        ctl.err_code = ERR_RANGE;
                        state_next   = S_OUT;
                    end
                    else if (status.hops_out)
                    begin
                        ctl.err_ld   = 1'b1;
                        ctl.err_code = ERR_HOPS;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        ctl.hop     = 1'b1;
                        ctl.rd_next = 1'b1;
                        state_next  = S_PTR;
                    end
                end
                else if (status.seen && status.name_full)
                begin
                    ctl.err_ld   = 1'b1;
                    ctl.err_code = ERR_TOO_LONG;
                    state_next   = S_OUT;
                end
                else
                begin
                    ctl.put_dot  = status.seen;
                    ctl.lbl_open = 1'b1;
                    state_next   = S_LBL;
                end
            end
            S_PTR:
            begin
                ctl.jump   = 1'b1;
                state_next = S_FETCH;
            end
            S_LBL:
            begin
                priority if (status.rem_zero)
                begin
                    state_next = S_FETCH;
                end
                else if (status.rp_oob)
                begin
                    ctl.err_ld   = 1'b1;
                    ctl.err_code = ERR_RANGE;
                    state_next   = S_OUT;
                end
                else if (status.name_full)
                begin
                    ctl.err_ld   = 1'b1;
                    ctl.err_code = ERR_TOO_LONG;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_CHR;
                end
            end
            S_CHR:
            begin
                ctl.put_char = 1'b1;
                state_next   = S_LBL;
            end
            S_FLUSH:
            begin
                ctl.flush  = 1'b1;
                state_next = S_EMIT_RD;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                ctl.emit_ld = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (status.out_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.emit_next = 1'b1;
                        state_next    = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/dnd_datapath.sv =====
// Decoder datapath: packet store, name row buffer, walk registers, result register.
// Depends on dnd_pkg and dnd_ram; steered by dnd_ctrl.
`default_nettype none

module dnd_datapath
    import dnd_pkg::*;
#(
    parameter int PACKET_BYTES   = PACKET_BYTES_DEF,
    parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dnd_cmd_t          ctl,
    output dnd_status_t            status,
    input  wire logic [8:0]        in_addr,
    input  wire logic [7:0]        in_value,
    input  wire logic [HOPS_W-1:0] max_hops,
    output logic      [31:0]       out_chars,
    output logic      [2:0]        out_count,
    output logic      [6:0]        out_len,
    output logic      [9:0]        out_end,
    output err_code_t              out_err,
    output logic                   out_last
);

    localparam int AW   = $clog2(PACKET_BYTES);
    localparam int CW   = $clog2(MAX_NAME_CHARS + 1);
    localparam int ROWS = MAX_NAME_CHARS / 4 + 1;
    localparam int RW   = $clog2(ROWS);
    localparam int LW   = ((CW > RW + 2) ? CW : RW + 2) + 1;

    logic [RP_W-1:0]   rp_reg;
    logic [7:0]        rem_reg;
    logic              seen_reg;
    logic [CW-1:0]     chars_reg;
    logic [HOPS_W-1:0] hops_reg;
    logic [5:0]        hi_reg;
    logic              have_end_reg;
    logic [9:0]        end_reg;
    logic [31:0]       group_reg;
    logic [RW-1:0]     row_reg;

    logic [RP_W-1:0] rp_plus1;
    logic [RP_W-1:0] rp_plus2;
    logic            in_in_range;
    logic [7:0]      pkt_rdata;
    logic [AW-1:0]   pkt_raddr;
    logic [31:0]     name_rdata;

    logic        app_en;
    logic [7:0]  app_char;
    logic [31:0] group_app;
    logic        row_full;
    logic        name_wr;
    logic [LW-1:0] left;
    logic        grp_last;

    assign rp_plus1    = rp_reg + RP_W'(1);
    assign rp_plus2    = rp_reg + RP_W'(2);
    assign in_in_range = RP_W'(in_addr) < RP_W'(PACKET_BYTES);
    assign pkt_raddr   = ctl.rd_next ? rp_plus1[AW-1:0] : rp_reg[AW-1:0];

    dnd_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_packet_ram (
        .clk     (clk),
        .wr_en   (ctl.store_wr && in_in_range),
        .wr_addr (AW'(in_addr)),
        .wr_data (in_value),
        .rd_addr (pkt_raddr),
        .rd_data (pkt_rdata)
    );

    // Characters are gathered four to a row; chars_reg[1:0] is the fill of the open row
    always_comb
    begin
        app_en    = ctl.put_dot | ctl.put_char;
        app_char  = ctl.put_dot ? DOT_CHAR : pkt_rdata;
        group_app = group_reg;
        group_app[{chars_reg[1:0], 3'b000} +: 8] = app_char;
        row_full  = app_en && (chars_reg[1:0] == 2'b11);
        name_wr   = row_full | ctl.flush;
    end

    dnd_ram #(
        .WIDTH (32),
        .DEPTH (ROWS)
    ) u_name_ram (
        .clk     (clk),
        .wr_en   (name_wr),
        .wr_addr (RW'(chars_reg >> 2)),
        .wr_data (ctl.flush ? group_reg : group_app),
        .rd_addr (row_reg),
        .rd_data (name_rdata)
    );

    assign left     = LW'(chars_reg) - LW'({row_reg, 2'b00});
    assign grp_last = (left <= LW'(4));

    assign status.rp_oob    = rp_reg >= RP_W'(PACKET_BYTES);
    assign status.next_oob  = rp_plus1 >= RP_W'(PACKET_BYTES);
    assign status.byte_zero = (pkt_rdata == 8'd0);
    assign status.byte_ptr  = (pkt_rdata[7:6] == 2'b11);
    assign status.hops_out  = (hops_reg >= max_hops);
    assign status.name_full = (chars_reg >= CW'(MAX_NAME_CHARS));
    assign status.seen      = seen_reg;
    assign status.rem_zero  = (rem_reg == 8'd0);
    assign status.out_last  = out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg       <= '0;
            rem_reg      <= '0;
            seen_reg     <= 1'b0;
            chars_reg    <= '0;
            hops_reg     <= '0;
            hi_reg       <= '0;
            have_end_reg <= 1'b0;
            end_reg      <= '0;
            group_reg    <= '0;
            row_reg      <= '0;
            out_chars    <= '0;
            out_count    <= '0;
            out_len      <= '0;
            out_end      <= '0;
            out_err      <= ERR_NONE;
            out_last     <= 1'b0;
        end
        else
        begin
            if (ctl.start)
            begin
                rp_reg       <= RP_W'(in_addr);
                rem_reg      <= '0;
                seen_reg     <= 1'b0;
                chars_reg    <= '0;
                hops_reg     <= '0;
                have_end_reg <= 1'b0;
                end_reg      <= '0;
                group_reg    <= '0;
                row_reg      <= '0;
            end

            if (ctl.set_end1 && !have_end_reg)
            begin
                end_reg <= rp_plus1[9:0];
            end
            if (ctl.set_end2 && !have_end_reg)
            begin
                end_reg      <= rp_plus2[9:0];
                have_end_reg <= 1'b1;
            end

            if (ctl.hop)
            begin
                hops_reg <= hops_reg + HOPS_W'(1);
                hi_reg   <= pkt_rdata[5:0];
            end
            if (ctl.jump)
            begin
                rp_reg <= RP_W'({hi_reg, pkt_rdata});
            end

            if (ctl.lbl_open)
            begin
                seen_reg <= 1'b1;
                rp_reg   <= rp_plus1;
                rem_reg  <= pkt_rdata;
            end
            if (ctl.put_char)
            begin
                rp_reg  <= rp_plus1;
                rem_reg <= rem_reg - 8'd1;
            end

            if (app_en)
            begin
                chars_reg <= chars_reg + CW'(1);
                group_reg <= row_full ? 32'd0 : group_app;
            end

            if (ctl.emit_next)
            begin
                row_reg <= row_reg + RW'(1);
            end

            if (ctl.emit_ld)
            begin
                out_chars <= name_rdata;
                out_count <= grp_last ? left[2:0] : 3'd4;
                out_len   <= grp_last ? 7'(chars_reg) : 7'd0;
                out_end   <= grp_last ? end_reg : 10'd0;
                out_err   <= ERR_NONE;
                out_last  <= grp_last;
            end
            if (ctl.err_ld)
            begin
                out_chars <= '0;
                out_count <= '0;
                out_len   <= '0;
                out_end   <= '0;
                out_err   <= ctl.err_code;
                out_last  <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/dns_name_decoder_core.sv =====
// DNS name decoder top level: stream ports, configuration register, core wiring.
// Depends on dnd_pkg, dnd_ctrl, dnd_datapath (and dnd_ram through the datapath).
`default_nettype none

// Input beats either write one byte into the packet store (tuser 0) or start
// a name decode at the given offset (tuser 1). A decode walks the packet store
// through its single read port with registered read data. A length byte
// visits FETCH, DECODE and LBL, a label character LBL and CHR, a compression
// pointer FETCH, DECODE and PTR, the terminator FETCH and DECODE; then FLUSH,
// and each result beat of four chars EMIT_RD, EMIT_LD and OUT plus any stall.
// Results of a decode are only released once the whole name has been walked,
// so an error gives one beat and no characters. The next input beat is taken
// once the last result has gone.
// max_pointer_hops sits at byte address 0 of the configuration port.

module dns_name_decoder_core
    import dnd_pkg::*;
#(
    parameter int PACKET_BYTES   = PACKET_BYTES_DEF,
    parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [8:0] byte_address, [16:9] byte_value, [23:17] zero
    input  wire logic [23:0] s_axis_tdata,
    // [0] cmd
    input  wire logic        s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] char_a, [15:8] char_b, [23:16] char_c, [31:24] char_d,
    // [34:32] char_count, [41:35] name_len, [51:42] end_offset, [55:52] zero
    output logic      [55:0] m_axis_tdata,
    // [1:0] error
    output logic      [1:0]  m_axis_tuser,
    output logic             m_axis_tlast,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [HOPS_W-1:0] max_hops_reg;
    dnd_cmd_t          ctl;
    dnd_status_t       status;
    logic [31:0]       out_chars;
    logic [2:0]        out_count;
    logic [6:0]        out_len;
    logic [9:0]        out_end;
    err_code_t         out_err;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_HOPS) ? {26'd0, max_hops_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_hops_reg <= HOPS_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_HOPS))
        begin
            max_hops_reg <= pwdata[HOPS_W-1:0];
        end
    end

    dnd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .ctl       (ctl)
    );

    dnd_datapath #(
        .PACKET_BYTES   (PACKET_BYTES),
        .MAX_NAME_CHARS (MAX_NAME_CHARS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .status    (status),
        .in_addr   (s_axis_tdata[8:0]),
        .in_value  (s_axis_tdata[16:9]),
        .max_hops  (max_hops_reg),
        .out_chars (out_chars),
        .out_count (out_count),
        .out_len   (out_len),
        .out_end   (out_end),
        .out_err   (out_err),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, out_end, out_len, out_count, out_chars};
    assign m_axis_tuser = out_err;

endmodule

`default_nettype wire
